FILE: sv/bsme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsme_pkg
// Types, constants and lookup functions for the thin-plate smoothing matrix
// element of tensor-product cubic B-splines.
// ----------------------------------------------------------------------------
package bsme_pkg;

    localparam int unsigned MAX_GRID   = 1024;
    localparam int unsigned IDX_W      = 10;
    localparam int unsigned SIZE_W     = 11;
    localparam int unsigned SCALE_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned ENT_W      = 32;   // table magnitude, 30 frac bits
    localparam int unsigned FAC_W      = 40;   // scaled factor magnitude
    localparam int unsigned HALF_W     = 20;   // split point of factor products
    localparam int unsigned PROD_W     = 53;   // product magnitude, 32 frac bits
    localparam int unsigned SUM_W      = 66;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_U           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_U       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_U_CUBED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_V           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_V       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_V_CUBED = 3'd7;

    localparam logic [SCALE_W-1:0] ONE_Q24 = 32'h0100_0000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 66'sd9223372036854775807;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -66'sd9223372036854775808;

    // inner product magnitudes, round(n/d * 2^30)
    localparam logic [ENT_W-1:0] QM_151_315  = 32'((64'd151 * 64'd2147483648 + 64'd315)
                                                   / (64'd2 * 64'd315));
    localparam logic [ENT_W-1:0] QM_397_1680 = 32'((64'd397 * 64'd2147483648 + 64'd1680)
                                                   / (64'd2 * 64'd1680));
    localparam logic [ENT_W-1:0] QM_1_42     = 32'((64'd2147483648 + 64'd42)
                                                   / (64'd2 * 64'd42));
    localparam logic [ENT_W-1:0] QM_1_5040   = 32'((64'd2147483648 + 64'd5040)
                                                   / (64'd2 * 64'd5040));
    localparam logic [ENT_W-1:0] QM_2_3      = 32'((64'd2 * 64'd2147483648 + 64'd3)
                                                   / (64'd2 * 64'd3));
    localparam logic [ENT_W-1:0] QM_1_8      = 32'((64'd2147483648 + 64'd8)
                                                   / (64'd2 * 64'd8));
    localparam logic [ENT_W-1:0] QM_1_5      = 32'((64'd2147483648 + 64'd5)
                                                   / (64'd2 * 64'd5));
    localparam logic [ENT_W-1:0] QM_1_120    = 32'((64'd2147483648 + 64'd120)
                                                   / (64'd2 * 64'd120));
    localparam logic [ENT_W-1:0] QM_8_3      = 32'((64'd8 * 64'd2147483648 + 64'd3)
                                                   / (64'd2 * 64'd3));
    localparam logic [ENT_W-1:0] QM_3_2      = 32'((64'd3 * 64'd2147483648 + 64'd2)
                                                   / (64'd2 * 64'd2));
    localparam logic [ENT_W-1:0] QM_1_6      = 32'((64'd2147483648 + 64'd6)
                                                   / (64'd2 * 64'd6));
    localparam logic [ENT_W-1:0] QM_599_1260 = 32'((64'd599 * 64'd2147483648 + 64'd1260)
                                                   / (64'd2 * 64'd1260));
    localparam logic [ENT_W-1:0] QM_151_630  = 32'((64'd151 * 64'd2147483648 + 64'd630)
                                                   / (64'd2 * 64'd630));
    localparam logic [ENT_W-1:0] QM_59_280   = 32'((64'd59 * 64'd2147483648 + 64'd280)
                                                   / (64'd2 * 64'd280));
    localparam logic [ENT_W-1:0] QM_1_252    = 32'((64'd2147483648 + 64'd252)
                                                   / (64'd2 * 64'd252));
    localparam logic [ENT_W-1:0] QM_43_1680  = 32'((64'd43 * 64'd2147483648 + 64'd1680)
                                                   / (64'd2 * 64'd1680));
    localparam logic [ENT_W-1:0] QM_1_84     = 32'((64'd2147483648 + 64'd84)
                                                   / (64'd2 * 64'd84));
    localparam logic [ENT_W-1:0] QM_37_60    = 32'((64'd37 * 64'd2147483648 + 64'd60)
                                                   / (64'd2 * 64'd60));
    localparam logic [ENT_W-1:0] QM_1_3      = 32'((64'd2147483648 + 64'd3)
                                                   / (64'd2 * 64'd3));
    localparam logic [ENT_W-1:0] QM_11_60    = 32'((64'd11 * 64'd2147483648 + 64'd60)
                                                   / (64'd2 * 64'd60));
    localparam logic [ENT_W-1:0] QM_1_20     = 32'((64'd2147483648 + 64'd20)
                                                   / (64'd2 * 64'd20));
    localparam logic [ENT_W-1:0] QM_7_120    = 32'((64'd7 * 64'd2147483648 + 64'd120)
                                                   / (64'd2 * 64'd120));
    localparam logic [ENT_W-1:0] QM_1_10     = 32'((64'd2147483648 + 64'd10)
                                                   / (64'd2 * 64'd10));
    localparam logic [ENT_W-1:0] QM_7_3      = 32'((64'd7 * 64'd2147483648 + 64'd3)
                                                   / (64'd2 * 64'd3));
    localparam logic [ENT_W-1:0] QM_4_3      = 32'((64'd4 * 64'd2147483648 + 64'd3)
                                                   / (64'd2 * 64'd3));
    localparam logic [ENT_W-1:0] QM_1_1      = 32'((64'd2147483648 + 64'd1)
                                                   / (64'd2 * 64'd1));
    localparam logic [ENT_W-1:0] QM_1_2      = 32'((64'd2147483648 + 64'd2)
                                                   / (64'd2 * 64'd2));

    typedef struct packed {
        logic [IDX_W-1:0] row_u_index;
        logic [IDX_W-1:0] row_v_index;
        logic [IDX_W-1:0] col_u_index;
        logic [IDX_W-1:0] col_v_index;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] element_value;
        logic               outside_band;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic             neg;
        logic [ENT_W-1:0] mag;
    } t_entry;

    // boundary cut-off count, saturating at 3; low end wins
    function automatic logic [1:0] cut_count(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                             logic [SIZE_W-1:0] n);
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic signed [12:0] d;
        logic [1:0]         q;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        d  = $signed({3'b000, hi}) - $signed({2'b00, n}) + 13'sd4;
        if (lo < 10'd3) begin
            q = 2'd3 - lo[1:0];
        end else if (d <= 13'sd0) begin
            q = 2'd0;
        end else if (d >= 13'sd3) begin
            q = 2'd3;
        end else begin
            q = d[1:0];
        end
        return q;
    endfunction

    // order: 0 value, 1 first derivative, 2 second derivative
    function automatic t_entry table_entry(logic [1:0] order, logic use_edge,
                                           logic [1:0] row, logic [1:0] col);
        t_entry e;
        e = '0;
        if (use_edge) begin
            unique case ({order, row, col})
                6'b00_00_00: e = '{1'b0, QM_599_1260};
                6'b00_01_00: e = '{1'b0, QM_151_630};
                6'b00_01_01: e = '{1'b0, QM_59_280};
                6'b00_10_00: e = '{1'b0, QM_1_252};
                6'b00_10_01: e = '{1'b0, QM_43_1680};
                6'b00_10_10: e = '{1'b0, QM_1_84};
                6'b01_00_00: e = '{1'b0, QM_37_60};
                6'b01_01_00: e = '{1'b0, QM_1_3};
                6'b01_01_01: e = '{1'b1, QM_11_60};
                6'b01_10_00: e = '{1'b0, QM_1_20};
                6'b01_10_01: e = '{1'b0, QM_7_120};
                6'b01_10_10: e = '{1'b1, QM_1_10};
                6'b10_00_00: e = '{1'b0, QM_7_3};
                6'b10_01_00: e = '{1'b0, QM_4_3};
                6'b10_01_01: e = '{1'b1, QM_1_1};
                6'b10_10_00: e = '{1'b0, QM_1_3};
                6'b10_10_01: e = '{1'b1, QM_1_2};
                default:     e = '0;
            endcase
        end else begin
            unique case ({order, col})
                4'b00_00: e = '{1'b0, QM_151_315};
                4'b00_01: e = '{1'b0, QM_397_1680};
                4'b00_10: e = '{1'b0, QM_1_42};
                4'b00_11: e = '{1'b0, QM_1_5040};
                4'b01_00: e = '{1'b0, QM_2_3};
                4'b01_01: e = '{1'b1, QM_1_8};
                4'b01_10: e = '{1'b1, QM_1_5};
                4'b01_11: e = '{1'b1, QM_1_120};
                4'b10_00: e = '{1'b0, QM_8_3};
                4'b10_01: e = '{1'b1, QM_3_2};
                4'b10_11: e = '{1'b0, QM_1_6};
                default:  e = '0;
            endcase
        end
        return e;
    endfunction

endpackage

FILE: sv/bspline_smoothing_matrix_element.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; stage 2 (32x32 scale multipliers) and
// stage 3 (20x20 partial products) set the clock, stages hold on output stall.
// Reset: synchronous, active low; clears pipeline valids and loads the
// configuration registers with grid size MAX_GRID and all scales 1.0.
// ----------------------------------------------------------------------------
// bspline_smoothing_matrix_element
// Five-stage pipeline: table select, factor scaling, split products,
// product rounding, saturating sum into the output register.
// ----------------------------------------------------------------------------
module bspline_smoothing_matrix_element (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bsme_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bsme_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bsme_pkg::t_in_word                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bsme_pkg::t_out_word                  o_out_data
);

    localparam int unsigned NSTG = 5;
    localparam int unsigned FW   = bsme_pkg::FAC_W;
    localparam int unsigned HW   = bsme_pkg::HALF_W;
    localparam int unsigned PW   = bsme_pkg::PROD_W;
    localparam int unsigned PPW  = 2 * HW;

    // configuration
    logic [bsme_pkg::SIZE_W-1:0]  r_cols, r_rows;
    logic [bsme_pkg::SCALE_W-1:0] r_scale_u [3];
    logic [bsme_pkg::SCALE_W-1:0] r_scale_v [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= bsme_pkg::SIZE_W'(bsme_pkg::MAX_GRID);
            r_rows <= bsme_pkg::SIZE_W'(bsme_pkg::MAX_GRID);
            for (int k = 0; k < 3; k++) begin
                r_scale_u[k] <= bsme_pkg::ONE_Q24;
                r_scale_v[k] <= bsme_pkg::ONE_Q24;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bsme_pkg::CFG_COLS_IN_USE:      r_cols <= i_cfg_data[bsme_pkg::SIZE_W-1:0];
                bsme_pkg::CFG_ROWS_IN_USE:      r_rows <= i_cfg_data[bsme_pkg::SIZE_W-1:0];
                bsme_pkg::CFG_STEP_U:           r_scale_u[0] <= i_cfg_data;
                bsme_pkg::CFG_INV_STEP_U:       r_scale_u[1] <= i_cfg_data;
                bsme_pkg::CFG_INV_STEP_U_CUBED: r_scale_u[2] <= i_cfg_data;
                bsme_pkg::CFG_STEP_V:           r_scale_v[0] <= i_cfg_data;
                bsme_pkg::CFG_INV_STEP_V:       r_scale_v[1] <= i_cfg_data;
                bsme_pkg::CFG_INV_STEP_V_CUBED: r_scale_v[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or when it drains
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: offsets, cut-off counts, table select
    logic [bsme_pkg::IDX_W-1:0] tu, tv;
    logic [1:0]                 qu, qv;
    logic                       edge_u, edge_v;
    bsme_pkg::t_entry           n_s1_ent_u [3];
    bsme_pkg::t_entry           n_s1_ent_v [3];
    bsme_pkg::t_entry           r_s1_ent_u [3];
    bsme_pkg::t_entry           r_s1_ent_v [3];
    logic                       n_s1_out, r_s1_out;

    always_comb begin
        tu = (i_in_data.row_u_index > i_in_data.col_u_index)
           ? i_in_data.row_u_index - i_in_data.col_u_index
           : i_in_data.col_u_index - i_in_data.row_u_index;
        tv = (i_in_data.row_v_index > i_in_data.col_v_index)
           ? i_in_data.row_v_index - i_in_data.col_v_index
           : i_in_data.col_v_index - i_in_data.row_v_index;
        n_s1_out = (|tu[bsme_pkg::IDX_W-1:2]) || (|tv[bsme_pkg::IDX_W-1:2]);
        qu = bsme_pkg::cut_count(i_in_data.row_u_index, i_in_data.col_u_index, r_cols);
        qv = bsme_pkg::cut_count(i_in_data.row_v_index, i_in_data.col_v_index, r_rows);
        edge_u = qu > tu[1:0];
        edge_v = qv > tv[1:0];
        for (int k = 0; k < 3; k++) begin
            n_s1_ent_u[k] = bsme_pkg::table_entry(2'(k), edge_u, qu - 2'd1, tu[1:0]);
            n_s1_ent_v[k] = bsme_pkg::table_entry(2'(k), edge_v, qv - 2'd1, tv[1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_ent_u <= n_s1_ent_u;
            r_s1_ent_v <= n_s1_ent_v;
            r_s1_out   <= n_s1_out;
        end
    end

    // stage 2: factor = entry * scale, rounded to 30 frac bits
    logic [FW-1:0] n_s2_mag_u [3];
    logic [FW-1:0] n_s2_mag_v [3];
    logic [FW-1:0] r_s2_mag_u [3];
    logic [FW-1:0] r_s2_mag_v [3];
    logic [2:0]    r_s2_neg_u, r_s2_neg_v;
    logic          r_s2_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s2_mag_u[k] = FW'((64'(r_s1_ent_u[k].mag) * 64'(r_scale_u[k])
                                 + 64'd8388608) >> 24);
            n_s2_mag_v[k] = FW'((64'(r_s1_ent_v[k].mag) * 64'(r_scale_v[k])
                                 + 64'd8388608) >> 24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_mag_u <= n_s2_mag_u;
            r_s2_mag_v <= n_s2_mag_v;
            for (int k = 0; k < 3; k++) begin
                r_s2_neg_u[k] <= r_s1_ent_u[k].neg;
                r_s2_neg_v[k] <= r_s1_ent_v[k].neg;
            end
            r_s2_out <= r_s1_out;
        end
    end

    // stage 3: products U2*V0, U1*V1, U0*V2 as four 20x20 partial products
    logic [FW-1:0]  pa [3];
    logic [FW-1:0]  pb [3];
    logic [PPW-1:0] n_s3_hh [3], n_s3_hl [3], n_s3_lh [3], n_s3_ll [3];
    logic [PPW-1:0] r_s3_hh [3], r_s3_hl [3], r_s3_lh [3], r_s3_ll [3];
    logic [2:0]     n_s3_neg, r_s3_neg;
    logic           r_s3_out;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            pa[p] = r_s2_mag_u[2-p];
            pb[p] = r_s2_mag_v[p];
            n_s3_neg[p] = r_s2_neg_u[2-p] ^ r_s2_neg_v[p];
            n_s3_hh[p] = PPW'(pa[p][FW-1:HW]) * PPW'(pb[p][FW-1:HW]);
            n_s3_hl[p] = PPW'(pa[p][FW-1:HW]) * PPW'(pb[p][HW-1:0]);
            n_s3_lh[p] = PPW'(pa[p][HW-1:0])  * PPW'(pb[p][FW-1:HW]);
            n_s3_ll[p] = PPW'(pa[p][HW-1:0])  * PPW'(pb[p][HW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_hh  <= n_s3_hh;
            r_s3_hl  <= n_s3_hl;
            r_s3_lh  <= n_s3_lh;
            r_s3_ll  <= n_s3_ll;
            r_s3_neg <= n_s3_neg;
            r_s3_out <= r_s2_out;
        end
    end

    // stage 4: assemble, round half up to 32 frac bits, apply sign
    logic [2*FW:0]         full [3];
    logic [PW-1:0]         mag  [3];
    logic signed [PW:0]    n_s4_prod [3];
    logic signed [PW:0]    r_s4_prod [3];
    logic                  r_s4_out;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            full[p] = ((2*FW+1)'(r_s3_hh[p]) << (2*HW))
                    + (((2*FW+1)'(r_s3_hl[p]) + (2*FW+1)'(r_s3_lh[p])) << HW)
                    + (2*FW+1)'(r_s3_ll[p])
                    + ((2*FW+1)'(1) << 27);
            mag[p] = PW'(full[p] >> 28);
            n_s4_prod[p] = r_s3_neg[p] ? -$signed({1'b0, mag[p]}) : $signed({1'b0, mag[p]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_prod <= n_s4_prod;
            r_s4_out  <= r_s3_out;
        end
    end

    // stage 5: E = p20 + 2*p11 + p02, clipped to Q32.32
    logic signed [bsme_pkg::SUM_W-1:0] sum;
    bsme_pkg::t_out_word               n_s5_word, r_s5_word;

    always_comb begin
        sum = bsme_pkg::SUM_W'(r_s4_prod[0])
            + (bsme_pkg::SUM_W'(r_s4_prod[1]) <<< 1)
            + bsme_pkg::SUM_W'(r_s4_prod[2]);
        n_s5_word = '0;
        if (r_s4_out) begin
            n_s5_word.outside_band = 1'b1;
        end else if (sum > bsme_pkg::SUM_MAX) begin
            n_s5_word.element_value = 64'(bsme_pkg::SUM_MAX);
            n_s5_word.saturated     = 1'b1;
        end else if (sum < bsme_pkg::SUM_MIN) begin
            n_s5_word.element_value = 64'(bsme_pkg::SUM_MIN);
            n_s5_word.saturated     = 1'b1;
        end else begin
            n_s5_word.element_value = 64'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_word <= n_s5_word;
        end
    end

    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_s5_word;

`ifndef NO_ASSERTIONS
    a_band_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.outside_band |->
            o_out_data.element_value == 64'sd0 && !o_out_data.saturated)
        else $error("outside_band word carries a nonzero value or saturation");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> &r_vld)
        else $error("input stalled while a pipeline stage is empty");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |-> !o_out_data.outside_band)
        else $error("saturated and outside_band both set");
`endif

endmodule

FILE: tb/tb_bspline_smoothing_matrix_element.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bspline_smoothing_matrix_element
// Streams index words into the smoothing matrix element pipeline under random
// input gaps and output stalls, predicts every element in fixed point from
// the register settings and checks each output word in order.
// ----------------------------------------------------------------------------
module tb_bspline_smoothing_matrix_element;
    import bsme_pkg::*;

    localparam int     QUIET_LIMIT = 2000;
    localparam int     PHASES      = 10;
    localparam int     RAND_WORDS  = 113;
    localparam longint ELEM_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ELEM_MIN    = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_data;

    bspline_smoothing_matrix_element i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow registers; scale index 0 step, 1 inverse, 2 inverse cubed
    logic [SIZE_W-1:0]  cols_n = SIZE_W'(MAX_GRID);
    logic [SIZE_W-1:0]  rows_n = SIZE_W'(MAX_GRID);
    logic [SCALE_W-1:0] scale_u [3] = '{ONE_Q24, ONE_Q24, ONE_Q24};
    logic [SCALE_W-1:0] scale_v [3] = '{ONE_Q24, ONE_Q24, ONE_Q24};

    t_in_word  index_words  [$];
    t_out_word elements_due [$];
    int        words_in     = 0;
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    logic      calm;

    assign calm = (words_in >= 300) && (words_in < 480);

    // ---------------- predictor ----------------
    function automatic longint q30(longint n, longint d);
        return (n * 64'sd2147483648 + d) / (2 * d);
    endfunction

    function automatic longint mid_entry(int order, int t);
        case (order)
            0: case (t)
                   0: return q30(151, 315);
                   1: return q30(397, 1680);
                   2: return q30(1, 42);
                   default: return q30(1, 5040);
               endcase
            1: case (t)
                   0: return q30(2, 3);
                   1: return -q30(1, 8);
                   2: return -q30(1, 5);
                   default: return -q30(1, 120);
               endcase
            default: case (t)
                   0: return q30(8, 3);
                   1: return -q30(3, 2);
                   2: return 0;
                   default: return q30(1, 6);
               endcase
        endcase
    endfunction

    // row = cut-off - 1, col = offset; above the diagonal is zero
    function automatic longint edge_entry(int order, int row, int col);
        case (order * 9 + row * 3 + col)
            0:  return q30(599, 1260);
            3:  return q30(151, 630);
            4:  return q30(59, 280);
            6:  return q30(1, 252);
            7:  return q30(43, 1680);
            8:  return q30(1, 84);
            9:  return q30(37, 60);
            12: return q30(1, 3);
            13: return -q30(11, 60);
            15: return q30(1, 20);
            16: return q30(7, 120);
            17: return -q30(1, 10);
            18: return q30(7, 3);
            21: return q30(4, 3);
            22: return -q30(1, 1);
            24: return q30(1, 3);
            25: return -q30(1, 2);
            default: return 0;
        endcase
    endfunction

    function automatic int cut_of(int a, int b, int n);
        int lo;
        int hi;
        int q;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        q  = 3 - lo;
        if (q <= 0) begin
            q = hi - (n - 4);
            if (q < 0) q = 0;
        end
        return (q > 3) ? 3 : q;
    endfunction

    // table value times Q8.24 scale, rounded half away from zero to 30 frac bits
    function automatic longint scaled(longint e, logic [SCALE_W-1:0] sc);
        logic [63:0] m;
        logic [65:0] p;
        m = (e < 0) ? -e : e;
        p = {2'b00, m} * {34'd0, sc};
        p = (p + (66'd1 << 23)) >> 24;
        return (e < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // 30x30 frac bits to 32 frac bits, same rounding
    function automatic longint prod32(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = {64'd0, ma} * {64'd0, mb};
        p   = (p + (128'd1 << 27)) >> 28;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint factor_of(int a, int b, int n, int order,
                                         logic [SCALE_W-1:0] sc);
        int     t;
        int     q;
        longint e;
        t = (a > b) ? a - b : b - a;
        q = cut_of(a, b, n);
        e = (q <= t) ? mid_entry(order, t) : edge_entry(order, q - 1, t);
        return scaled(e, sc);
    endfunction

    function automatic t_out_word element_of(t_in_word w);
        t_out_word         o;
        int                i, j, r, s, tu, tv, k;
        longint            fu [3];
        longint            fv [3];
        longint            terms [4];
        longint            acc;
        logic signed [65:0] wide;
        i  = w.row_u_index;
        j  = w.row_v_index;
        r  = w.col_u_index;
        s  = w.col_v_index;
        tu = (i > r) ? i - r : r - i;
        tv = (j > s) ? j - s : s - j;
        o  = '0;
        if (tu >= 4 || tv >= 4) begin
            o.outside_band = 1'b1;
            return o;
        end
        for (k = 0; k < 3; k++) begin
            fu[k] = factor_of(i, r, cols_n, k, scale_u[k]);
            fv[k] = factor_of(j, s, rows_n, k, scale_v[k]);
        end
        terms[0] = prod32(fu[2], fv[0]);
        terms[1] = prod32(fu[1], fv[1]);
        terms[2] = terms[1];
        terms[3] = prod32(fu[0], fv[2]);
        acc = terms[0];
        for (k = 1; k < 4; k++) begin
            wide = acc;
            wide = wide + terms[k];
            if (wide > ELEM_MAX) begin
                acc = ELEM_MAX;
                o.saturated = 1'b1;
            end else if (wide < ELEM_MIN) begin
                acc = ELEM_MIN;
                o.saturated = 1'b1;
            end else begin
                acc = wide[63:0];
            end
        end
        o.element_value = acc;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [IDX_W-1:0] clip_index(int x);
        if (x < 0) return '0;
        if (x > 1023) return 10'd1023;
        return x[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] near_index(int n);
        case ($urandom_range(2))
            0: return clip_index(int'($urandom_range(6)));
            1: return clip_index(n - 1 - int'($urandom_range(6)));
            default: return clip_index(int'($urandom_range(1023)));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] partner(int a, int spread);
        return clip_index(a + int'($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic t_in_word pick_word(int nu, int nv);
        t_in_word    w;
        logic [63:0] rb;
        int          mode;
        mode = int'($urandom_range(99));
        rb   = {$urandom, $urandom};
        w    = rb[39:0];
        if (mode < 85) begin
            w.row_u_index = near_index(nu);
            w.col_u_index = partner(w.row_u_index, (mode < 10) ? 5 : 3);
            w.row_v_index = near_index(nv);
            w.col_v_index = partner(w.row_v_index, (mode >= 75) ? 5 : 3);
        end
        return w;
    endfunction

    function automatic int rand_size();
        if ($urandom_range(99) < 80) return int'($urandom_range(1024, 6));
        return int'($urandom_range(2047));
    endfunction

    task automatic add_word(int i, int j, int r, int s);
        t_in_word w;
        w.row_u_index = IDX_W'(i);
        w.row_v_index = IDX_W'(j);
        w.col_u_index = IDX_W'(r);
        w.col_v_index = IDX_W'(s);
        index_words.push_back(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COLS_IN_USE:      cols_n     = val[SIZE_W-1:0];
            CFG_ROWS_IN_USE:      rows_n     = val[SIZE_W-1:0];
            CFG_STEP_U:           scale_u[0] = val;
            CFG_INV_STEP_U:       scale_u[1] = val;
            CFG_INV_STEP_U_CUBED: scale_u[2] = val;
            CFG_STEP_V:           scale_v[0] = val;
            CFG_INV_STEP_V:       scale_v[1] = val;
            default:              scale_v[2] = val;
        endcase
    endtask

    task automatic apply_setting(int nu, int nv,
                                 logic [SCALE_W-1:0] su, logic [SCALE_W-1:0] isu,
                                 logic [SCALE_W-1:0] isu3, logic [SCALE_W-1:0] sv,
                                 logic [SCALE_W-1:0] isv, logic [SCALE_W-1:0] isv3);
        write_reg(CFG_COLS_IN_USE, CFG_DATA_W'(nu));
        write_reg(CFG_ROWS_IN_USE, CFG_DATA_W'(nv));
        write_reg(CFG_STEP_U, su);
        write_reg(CFG_INV_STEP_U, isu);
        write_reg(CFG_INV_STEP_U_CUBED, isu3);
        write_reg(CFG_STEP_V, sv);
        write_reg(CFG_INV_STEP_V, isv);
        write_reg(CFG_INV_STEP_V_CUBED, isv3);
    endtask

    task automatic wait_drained();
        while (index_words.size() != 0 || i_in_valid || elements_due.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------- sequence ----------------
    initial begin
        int p;
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    // reset values: corners, every cut-off and offset, band edges
                    add_word(0, 0, 0, 0);
                    add_word(1, 1, 1, 1);
                    add_word(2, 2, 2, 2);
                    add_word(3, 3, 3, 3);
                    add_word(0, 0, 1, 1);
                    add_word(0, 0, 2, 2);
                    add_word(0, 0, 3, 3);
                    add_word(1, 1, 2, 2);
                    add_word(5, 7, 6, 4);
                    add_word(100, 200, 103, 198);
                    add_word(1023, 1023, 1023, 1023);
                    add_word(1022, 1021, 1020, 1021);
                    add_word(1021, 1023, 1021, 1022);
                    add_word(1019, 1019, 1019, 1019);
                    add_word(0, 500, 4, 500);
                    add_word(500, 0, 500, 4);
                    add_word(0, 0, 1023, 1023);
                    add_word(1023, 1023, 1019, 1020);
                    add_word(10'h2AA, 10'h155, 10'h2A9, 10'h156);
                    add_word(3, 1020, 0, 1023);
                end
                1: begin
                    apply_setting(6, 6, ONE_Q24, ONE_Q24, ONE_Q24,
                                  ONE_Q24, ONE_Q24, ONE_Q24);
                    // 6 by 6 grid: cut-off from both ends at once
                    add_word(1, 1, 4, 4);
                    add_word(5, 5, 5, 5);
                    add_word(2, 0, 4, 3);
                    add_word(0, 5, 3, 2);
                end
                2: apply_setting(2047, 2047, '1, '1, '1, '1, '1, '1);
                3: apply_setting(0, 7, '0, '0, '0, '0, '0, '0);
                4: apply_setting(1024, 1024, 32'h0080_0000, 32'h0200_0000, 32'h0800_0000,
                                 32'h0400_0000, 32'h0040_0000, 32'h0004_0000);
                5: apply_setting(1024, 6, '1, 32'd1, '1, 32'd1, '1, 32'd1);
                default: apply_setting(rand_size(), rand_size(), $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom);
            endcase
            for (k = 0; k < RAND_WORDS; k++)
                index_words.push_back(pick_word(cols_n, rows_n));
            wait_drained();
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                elements_due.push_back(element_of(i_in_data));
                words_in <= words_in + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (index_words.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= index_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 32);
            if (o_out_valid && !i_out_stall) begin
                if (elements_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    want = elements_due.pop_front();
                    if (o_out_data.element_value !== want.element_value) begin
                        $display("%0t: element_value expected %h actual %h",
                                 $time, want.element_value, o_out_data.element_value);
                        mismatches++;
                    end
                    if (o_out_data.outside_band !== want.outside_band) begin
                        $display("%0t: outside_band expected %b actual %b",
                                 $time, want.outside_band, o_out_data.outside_band);
                        mismatches++;
                    end
                    if (o_out_data.saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want.saturated, o_out_data.saturated);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

FILE: files.f
sv/bsme_pkg.sv
sv/bspline_smoothing_matrix_element.sv
tb/tb_bspline_smoothing_matrix_element.sv
